FILE: rtl/pcfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfg_pkg
// Shared types and constants of the type 0 configuration header block.
// ----------------------------------------------------------------------------
package pcfg_pkg;

  // opcodes of an incoming word
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  // register kinds
  localparam logic [2:0] KIND_HWI   = 3'd0;
  localparam logic [2:0] KIND_RO    = 3'd1;
  localparam logic [2:0] KIND_RW    = 3'd2;
  localparam logic [2:0] KIND_BAR   = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  // register indexes
  localparam logic [4:0] NUM_REGS  = 5'd17;
  localparam logic [4:0] IDX_CMD   = 5'd2;
  localparam logic [4:0] IDX_STS   = 5'd3;
  localparam logic [4:0] IDX_CLASS = 5'd5;
  localparam logic [4:0] IDX_BAR0  = 5'd7;
  localparam logic [4:0] IDX_BAR3  = 5'd10;
  localparam logic [4:0] IDX_ROM   = 5'd15;

  // read-only masks and fixed values
  localparam logic [31:0] CMD_RO_MASK    = 32'hFFFF_FABC;
  localparam logic [31:0] STS_RO_MASK    = 32'hFFFF_5EFF;
  localparam logic [31:0] ROM_RO_MASK    = 32'h0000_07FE;
  localparam logic [31:0] DEV_CLASS_WORD = 32'h0008_0080;
  localparam logic [31:0] STS_BIT14      = 32'h0000_4000;
  localparam logic [31:0] STS_BIT8       = 32'h0000_0100;
  localparam logic [31:0] STS_ABORT_CLR  = 32'hFFFF_DFFF;
  localparam logic [31:0] STS_ABORT_SET  = 32'h0000_2000;

  // command bits that gate other writes
  localparam int CMD_ROM_EN_BIT = 1;
  localparam int CMD_STS8_BIT   = 6;
  localparam int CMD_STS14_BIT  = 8;

  // reset values
  localparam logic [31:0] CMD_RESET = 32'd3;
  localparam logic [31:0] STS_RESET = 32'd17;
  localparam logic [31:0] ROM_RESET = 32'd0;
  localparam logic [3:0][31:0] BAR_RESET = {32'd1, 32'd0, 32'd0, 32'd12};
  localparam logic [3:0][31:0] BAR_MASK  =
    {32'h0000_0FFF, 32'h03FF_FFFF, 32'h0000_0000, 32'h3FFF_FFFF};

  // write strobes from decode to register file
  typedef struct packed {
    logic       cmd_we;
    logic       sts_we;
    logic       bar_we;
    logic [1:0] bar_sel;
    logic       rom_we;
    logic       abort;
  } wr_ctrl_t;

  // kind of a register by index
  function automatic logic [2:0] reg_kind_of(input logic [4:0] idx);
    logic [2:0] k;
    unique case (idx)
      5'd0, 5'd1, 5'd4, 5'd13, 5'd14:        k = KIND_HWI;
      5'd2, 5'd3, 5'd15:                     k = KIND_RW;
      5'd5, 5'd6, 5'd16:                     k = KIND_RO;
      5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12: k = KIND_BAR;
      default:                               k = KIND_EMPTY;
    endcase
    return k;
  endfunction

  // old bits under the mask, new bits elsewhere
  function automatic logic [31:0] merge(input logic [31:0] old_val,
                                        input logic [31:0] new_val,
                                        input logic [31:0] ro_mask);
    return (old_val & ro_mask) | (new_val & ~ro_mask);
  endfunction

endpackage

FILE: rtl/pcfg_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfg_decode
// Decodes one word into write strobes, read enable, completion flag and kind.
// ----------------------------------------------------------------------------
module pcfg_decode (
  input  logic [1:0]        opcode,
  input  logic [4:0]        reg_index,
  input  logic              cmd_rom_en,
  output pcfg_pkg::wr_ctrl_t ctrl,
  output logic              rd_en,
  output logic              accepted,
  output logic [2:0]        reg_kind
);
  import pcfg_pkg::*;

  logic       in_range;
  logic [2:0] kind;
  logic [4:0] bar_off;
  logic       is_bar;

  assign in_range = reg_index < NUM_REGS;
  assign kind     = reg_kind_of(reg_index);
  assign bar_off  = reg_index - IDX_BAR0;
  assign is_bar   = (reg_index >= IDX_BAR0) && (reg_index <= IDX_BAR3);

  // per-opcode decisions
  always_comb begin
    ctrl         = '0;
    ctrl.bar_sel = bar_off[1:0];
    rd_en        = 1'b0;
    accepted     = 1'b0;
    reg_kind     = KIND_EMPTY;
    unique case (opcode)
      OP_READ: begin
        rd_en    = in_range;
        accepted = in_range;
        reg_kind = kind;
      end
      OP_WRITE: begin
        ctrl.cmd_we = reg_index == IDX_CMD;
        ctrl.sts_we = reg_index == IDX_STS;
        ctrl.bar_we = is_bar;
        ctrl.rom_we = (reg_index == IDX_ROM) && cmd_rom_en;
        accepted    = ctrl.cmd_we | ctrl.sts_we | ctrl.bar_we | ctrl.rom_we;
        reg_kind    = kind;
      end
      OP_ABORT: begin
        ctrl.abort = 1'b1;
        accepted   = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/pcfg_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfg_regfile
// Writable header registers with masked merge and the register read mux.
// ----------------------------------------------------------------------------
module pcfg_regfile (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  pcfg_pkg::wr_ctrl_t ctrl,
  input  logic [31:0]       write_data,
  input  logic [4:0]        reg_index,
  output logic [31:0]       rd_val,
  output logic [31:0]       command_word,
  output logic [31:0]       status_word
);
  import pcfg_pkg::*;

  logic [31:0]       rom_base_word;
  logic [3:0][31:0]  bar_words;
  logic [31:0]       sts_val;
  logic [4:0]        rd_bar_off;

  // status write drops bits whose enables in command are clear
  always_comb begin
    sts_val = write_data;
    if (!command_word[CMD_STS14_BIT]) begin
      sts_val = sts_val & ~STS_BIT14;
    end
    if (!command_word[CMD_STS8_BIT]) begin
      sts_val = sts_val & ~STS_BIT8;
    end
  end

  // register updates
  always_ff @(posedge clk) begin
    if (rst) begin
      command_word  <= CMD_RESET;
      status_word   <= STS_RESET;
      bar_words     <= BAR_RESET;
      rom_base_word <= ROM_RESET;
    end else if (en) begin
      if (ctrl.cmd_we) begin
        command_word <= merge(command_word, write_data, CMD_RO_MASK);
      end
      if (ctrl.sts_we) begin
        status_word <= merge(status_word, sts_val, STS_RO_MASK);
      end else if (ctrl.abort) begin
        status_word <= (status_word & STS_ABORT_CLR) | STS_ABORT_SET;
      end
      if (ctrl.bar_we) begin
        bar_words[ctrl.bar_sel] <= merge(bar_words[ctrl.bar_sel], write_data,
                                         BAR_MASK[ctrl.bar_sel]);
      end
      if (ctrl.rom_we) begin
        rom_base_word <= merge(rom_base_word, write_data, ROM_RO_MASK);
      end
    end
  end

  // read mux
  assign rd_bar_off = reg_index - IDX_BAR0;

  always_comb begin
    unique case (reg_index)
      IDX_CMD:                 rd_val = command_word;
      IDX_STS:                 rd_val = status_word;
      IDX_CLASS:               rd_val = DEV_CLASS_WORD;
      5'd7, 5'd8, 5'd9, 5'd10: rd_val = bar_words[rd_bar_off[1:0]];
      IDX_ROM:                 rd_val = rom_base_word;
      default:                 rd_val = '0;
    endcase
  end

endmodule

FILE: rtl/pcie_type0_config_space_regs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcie_type0_config_space_regs_core
// Type 0 endpoint configuration header: 17 registers, read / masked write /
// master abort, one completion word per request word.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser
// s_*       in   [4:0] reg_index, [36:5] write_data      [1:0] opcode
// m_*       out  [31:0] read_data, [32] accepted         [2:0] reg_kind
//
// One word per cycle while the output is not stalled; a word passes the input
// register, then decode and register update into the output register.
// The register update and the completion happen in the same cycle, so the
// next word already sees the new register values.
// rst clears the valid flags and loads the header reset values.
// A stalled output holds its word; the input register keeps taking words
// as long as its content can move on.
// ----------------------------------------------------------------------------
module pcie_type0_config_space_regs_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // reg_index[4:0], write_data[36:5], zero pad
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_data[31:0], accepted[32], zero pad
  output logic [2:0]  m_tuser    // reg_kind[2:0]
);
  import pcfg_pkg::*;

  logic        in_valid;
  logic [1:0]  in_op;
  logic [4:0]  in_idx;
  logic [31:0] in_wdata;
  logic        out_valid;
  logic [31:0] out_data;
  logic        out_acc;
  logic [2:0]  out_kind;
  logic        adv;
  wr_ctrl_t    ctrl;
  logic        rd_en;
  logic        acc;
  logic [2:0]  kind;
  logic [31:0] rd_val;
  logic [31:0] command_word;
  logic [31:0] status_word;

  // handshake
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op    <= s_tuser;
      in_idx   <= s_tdata[4:0];
      in_wdata <= s_tdata[36:5];
    end
  end

  pcfg_decode u_decode (
    .opcode     (in_op),
    .reg_index  (in_idx),
    .cmd_rom_en (command_word[CMD_ROM_EN_BIT]),
    .ctrl       (ctrl),
    .rd_en      (rd_en),
    .accepted   (acc),
    .reg_kind   (kind)
  );

  pcfg_regfile u_regfile (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .ctrl         (ctrl),
    .write_data   (in_wdata),
    .reg_index    (in_idx),
    .rd_val       (rd_val),
    .command_word (command_word),
    .status_word  (status_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= rd_en ? rd_val : '0;
      out_acc  <= acc;
      out_kind <= kind;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_acc, out_data};
  assign m_tuser  = out_kind;

  // checks
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
    else $error("refused completion carries data");

  a_sts_fixed_bit: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> status_word[4])
    else $error("read-only status bit changed");

  a_abort_sets: assert property (@(posedge clk) disable iff (rst)
    adv && ctrl.abort |=> status_word[13])
    else $error("master abort not recorded");

  a_read_only_cmd: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !(adv && ctrl.cmd_we) |=> $stable(command_word))
    else $error("command changed without a write");

endmodule
